>>> hw/rtl/mask_corner_vertex_extract_macros.svh
// Assertion macros shared by the corner vertex extractor RTL.
// Depends on nothing; defining ASSERT_OFF compiles every check away.
`ifndef MASK_CORNER_VERTEX_EXTRACT_MACROS_SVH
`define MASK_CORNER_VERTEX_EXTRACT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define MCVE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcve assertion failed");

// Next-cycle implication, disabled during reset.
`define MCVE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcve assertion failed");

`else

`define MCVE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MCVE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/mcve_pkg.sv
// Package of the corner vertex extractor: field widths, defaults and payload types.
// Depends on nothing; used by every module of the block.
package mcve_pkg;

   localparam int WIDTH_DEFAULT      = 32;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   localparam int ROW_BITS_W    = 32;
   localparam int IMAGE_WIDTH_W = 6;
   localparam int VERTEX_X_W    = 6;
   localparam int VERTEX_Y_W    = 10;

   localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RESET = 6'd32;

   // One input transaction.
   typedef struct packed {
      logic [ROW_BITS_W-1:0] row_bits;
      logic                  end_frame;
   } req_payload_type;

   // One result transaction.
   typedef struct packed {
      logic [VERTEX_X_W-1:0] vertex_x;
      logic [VERTEX_Y_W-1:0] vertex_y;
      logic                  last;
   } rsp_payload_type;

   // Neighborhood of one column as seen by its lane.
   typedef struct packed {
      logic self_bit;
      logic left_bit;
      logic right_bit;
      logic above_bit;
      logic below_bit;
   } lane_in_type;

   // Start command from the row stage to the scan stage.
   typedef struct packed {
      logic                  load;
      logic                  toggle;
      logic [VERTEX_Y_W-1:0] vertex_y;
   } scan_load_type;

endpackage

>>> hw/rtl/mcve_lane.sv
// One column lane: judges whether its pixel of the pending row is a corner.
// Depends on mcve_pkg for the neighborhood struct and the register width.
module mcve_lane
   import mcve_pkg::*;
#(
   parameter int COL = 0
) (
   input  logic [IMAGE_WIDTH_W-1:0] image_width,
   input  lane_in_type              nbr,
   output logic                     col_valid,
   output logic                     hit
);

   logic right_valid;

   // A column counts only below the programmed image width.
   assign col_valid   = {1'b0, image_width} > (IMAGE_WIDTH_W+1)'(COL);
   assign right_valid = {1'b0, image_width} > (IMAGE_WIDTH_W+1)'(COL + 1);

   // Exactly one horizontal and exactly one vertical opaque neighbor.
   assign hit = col_valid & nbr.self_bit
              & (nbr.left_bit ^ (nbr.right_bit & right_valid))
              & (nbr.above_bit ^ nbr.below_bit);

endmodule

>>> hw/rtl/mcve_scan.sv
// Merge stage: walks lane hits one column per unstalled cycle and emits vertices.
// Depends on mcve_pkg and the assertion macro header.
`include "mask_corner_vertex_extract_macros.svh"
module mcve_scan
   import mcve_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  scan_load_type   load,
   input  logic [WIDTH-1:0] load_hits,
   output logic            busy,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int XW = $clog2(WIDTH);

   logic [WIDTH-1:0]      hits_ff, hits_in;
   logic [XW-1:0]         x_ff, x_in;
   logic                  tog_ff, tog_in;
   logic [VERTEX_Y_W-1:0] y_ff, y_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;
   logic                  out_free;
   logic                  step;
   logic                  emit;
   logic                  last_hit;

   // The scan advances unless a hit is waiting for a free output register.
   assign busy     = hits_ff != '0;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step     = busy && (!hits_ff[0] || out_free);
   assign emit     = step && hits_ff[0];
   assign last_hit = (hits_ff >> 1) == '0;

   // Scan position and offset toggle.
   always_comb begin
      hits_in = hits_ff;
      x_in    = x_ff;
      tog_in  = tog_ff;
      y_in    = y_ff;
      if (load.load) begin
         hits_in = load_hits;
         x_in    = '0;
         tog_in  = load.toggle;
         y_in    = load.vertex_y;
      end else if (step) begin
         hits_in = hits_ff >> 1;
         x_in    = x_ff + 1'b1;
         tog_in  = tog_ff ^ emit;
      end
   end

   // Output register, loaded on every emitted vertex.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.vertex_x = VERTEX_X_W'(x_ff) + VERTEX_X_W'(tog_ff);
         rsp_data_in.vertex_y = y_ff;
         rsp_data_in.last     = last_hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      tog_ff      <= tog_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // A new row must never arrive while a scan is in progress.
   `MCVE_ASSERT_IMPLIES(a_load_when_idle, clock, reset, load.load, !busy)
   // Emitting the last vertex of a row ends the scan.
   `MCVE_ASSERT_NEXT(a_last_ends_scan, clock, reset, emit && last_hit, hits_ff == '0)
   // The scan position stays inside the row while hits remain.
   `MCVE_ASSERT_IMPLIES(a_x_in_row, clock, reset, busy, {1'b0, x_ff} < (XW+1)'(WIDTH))

endmodule

>>> hw/rtl/mask_corner_vertex_extract.sv
// Path: at the accepting edge the corner hits of a judged row load the merge stage, which
// scans them one column per cycle and loads each vertex into the output register, delayed
// beyond that only while the result side stalls. Throughput: a transaction that judges
// corners holds the input while the merge stage scans up to its highest corner column,
// plus output stalls. A transaction that judges no corner is taken every cycle.
// Reset (synchronous, active high): row state cleared, above row all ones, image_width 32.
`include "mask_corner_vertex_extract_macros.svh"
module mask_corner_vertex_extract
   import mcve_pkg::*;
#(
   parameter int WIDTH      = WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_payload_type          req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_payload_type          rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [IMAGE_WIDTH_W-1:0] csr_data
);

   localparam int IW = $clog2(MAX_HEIGHT);

   logic [IMAGE_WIDTH_W-1:0] width_ff, width_in;
   logic [WIDTH-1:0]         pending_ff, pending_in;
   logic [WIDTH-1:0]         above_ff, above_in;
   logic [IW-1:0]            row_idx_ff, row_idx_in;
   logic                     have_pend_ff, have_pend_in;
   logic                     tog_ff, tog_in;
   logic [WIDTH-1:0]         row_ext;
   logic [WIDTH-1:0]         col_valid;
   logic [WIDTH-1:0]         hits;
   lane_in_type              lane_in [WIDTH];
   scan_load_type            scan_load;
   logic                     scan_busy;
   logic                     req_fire;

   assign req_ready = !scan_busy;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign row_ext   = WIDTH'(req_payload.row_bits);

   // One lane per column; the row below is opaque on an end transaction.
   for (genvar x = 0; x < WIDTH; x++) begin : g_lane
      assign lane_in[x].self_bit  = pending_ff[x];
      assign lane_in[x].above_bit = above_ff[x];
      assign lane_in[x].below_bit = req_payload.end_frame | row_ext[x];
      if (x == 0) begin : g_left_edge
         assign lane_in[x].left_bit = 1'b0;
      end else begin : g_left
         assign lane_in[x].left_bit = pending_ff[x-1];
      end
      if (x == WIDTH - 1) begin : g_right_edge
         assign lane_in[x].right_bit = 1'b0;
      end else begin : g_right
         assign lane_in[x].right_bit = pending_ff[x+1];
      end
      mcve_lane #(
         .COL(x)
      ) u_lane (
         .image_width(width_ff),
         .nbr        (lane_in[x]),
         .col_valid  (col_valid[x]),
         .hit        (hits[x])
      );
   end

   // Start a scan whenever a pending row gets judged.
   assign scan_load.load     = req_fire && have_pend_ff;
   assign scan_load.toggle   = tog_ff;
   assign scan_load.vertex_y = VERTEX_Y_W'(row_idx_ff);

   // Configuration register.
   always_comb begin
      width_in = width_ff;
      if (csr_valid) begin
         width_in = csr_data;
      end
   end

   // Row history, row counter and offset parity.
   always_comb begin
      pending_in   = pending_ff;
      above_in     = above_ff;
      row_idx_in   = row_idx_ff;
      have_pend_in = have_pend_ff;
      tog_in       = tog_ff;
      if (req_fire) begin
         if (req_payload.end_frame) begin
            pending_in   = '0;
            above_in     = '1;
            row_idx_in   = '0;
            have_pend_in = 1'b0;
            tog_in       = 1'b0;
         end else begin
            if (have_pend_ff) begin
               above_in = pending_ff;
               tog_in   = tog_ff ^ (^hits);
               if (row_idx_ff != IW'(MAX_HEIGHT - 1)) begin
                  row_idx_in = row_idx_ff + 1'b1;
               end
            end
            pending_in   = row_ext & col_valid;
            have_pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= IMAGE_WIDTH_RESET;
         pending_ff   <= '0;
         above_ff     <= '1;
         row_idx_ff   <= '0;
         have_pend_ff <= 1'b0;
         tog_ff       <= 1'b0;
      end else begin
         width_ff     <= width_in;
         pending_ff   <= pending_in;
         above_ff     <= above_in;
         row_idx_ff   <= row_idx_in;
         have_pend_ff <= have_pend_in;
         tog_ff       <= tog_in;
      end
   end

   // Merge stage and output register.
   mcve_scan #(
      .WIDTH(WIDTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .load       (scan_load),
      .load_hits  (hits),
      .busy       (scan_busy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // An end transaction leaves the frame state cleared.
   `MCVE_ASSERT_NEXT(a_end_clears, clock, reset, req_fire && req_payload.end_frame,
                     !have_pend_ff && row_idx_ff == '0 && !tog_ff)
   // Without a pending row the row register holds nothing.
   `MCVE_ASSERT_IMPLIES(a_idle_pending_clear, clock, reset, !have_pend_ff, pending_ff == '0)
   // A stalled result transaction stays offered with its payload unchanged.
   `MCVE_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule
